/* rtl/core/tag_ordered_result_bus_queue_defines.svh */
// Assertion macros shared by the tag-ordered result bus queue RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef TAG_ORDERED_RESULT_BUS_QUEUE_DEFINES_SVH
`define TAG_ORDERED_RESULT_BUS_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TORBQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TORBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/torbq_pkg.sv */
// Package for the tag-ordered result bus queue: sizes, payload structs and the
// command and status structs between controller and datapath. No dependencies.
package torbq_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int ROB_ENTRIES = 16;
    localparam int VALUE_BITS  = 64;

    localparam int PTR_W   = $clog2(QUEUE_SLOTS);
    localparam int TAG_W   = 4;
    localparam int ROB_W   = $clog2(ROB_ENTRIES);
    localparam int WORD_W  = 64;
    localparam int OCC_W   = 4;
    localparam int ENTRY_W = TAG_W + VALUE_BITS;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_SQUASH  = 2'd1,
        REQ_TICK    = 2'd2
    } t_req_code;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TAG_W-1:0]  tag;
        logic [WORD_W-1:0] value;
        logic [TAG_W-1:0]  rob_front;
        logic [TAG_W-1:0]  rob_rear;
    } t_req;

    typedef struct packed {
        logic              status;
        logic              bus_valid;
        logic [TAG_W-1:0]  bus_tag;
        logic [WORD_W-1:0] bus_value;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        RD_PREV_IDX  = 2'd0,
        RD_PREV_TAIL = 2'd1,
        RD_HEAD      = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    latch;
        logic    set_full;
        logic    idx_init;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    wr_new;
        logic    tail_back;
        logic    bus_load;
        logic    bus_squash;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       empty;
        logic       idx_at_head;
        logic       prev_tail_at_head;
        logic       shift_ok;
        logic       younger_rd;
    } t_stat;

endpackage

/* rtl/core/torbq_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module torbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/torbq_datapath.sv */
// Datapath of the result bus queue: slot memory, pointers, bus register and age test.
// Depends on torbq_pkg and torbq_ram.
module torbq_datapath import torbq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output t_result o_result
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
    localparam logic [ROB_W:0]   ROB_SIZE  = (ROB_W + 1)'(ROB_ENTRIES);
    localparam logic [PTR_W:0]   SLOT_SIZE = (PTR_W + 1)'(QUEUE_SLOTS);

    function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    function automatic logic [ROB_W:0] rob_dist(input logic [TAG_W-1:0] x,
                                                input logic [TAG_W-1:0] f);
        logic [ROB_W:0] s;
        s = (ROB_W + 1)'(x) + ROB_SIZE - (ROB_W + 1)'(f);
        if (s >= ROB_SIZE) begin
            s = s - ROB_SIZE;
        end
        return s;
    endfunction

    function automatic logic is_younger(input logic [TAG_W-1:0] a,
                                        input logic [TAG_W-1:0] b,
                                        input logic [TAG_W-1:0] f,
                                        input logic [TAG_W-1:0] r);
        logic [ROB_W:0] da;
        logic [ROB_W:0] db;
        logic [ROB_W:0] len;
        da  = rob_dist(a, f);
        db  = rob_dist(b, f);
        len = rob_dist(r, f);
        return (da < db) && (db < len);
    endfunction

    t_req                  r_req;
    logic [PTR_W-1:0]      r_head;
    logic [PTR_W-1:0]      r_tail;
    logic [PTR_W-1:0]      r_idx;
    logic                  r_status;
    logic                  r_bus_holds;
    logic [TAG_W-1:0]      r_bus_tag;
    logic [VALUE_BITS-1:0] r_bus_value;

    logic [PTR_W-1:0]   w_prev_idx;
    logic [PTR_W-1:0]   w_prev_tail;
    logic [PTR_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_rd_entry;
    t_entry             w_wr_entry;
    logic [PTR_W:0]     w_occ;

    assign w_prev_idx  = slot_prev(r_idx);
    assign w_prev_tail = slot_prev(r_tail);
    assign w_rd_entry  = t_entry'(w_rdata);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV_IDX:  w_raddr = w_prev_idx;
            RD_PREV_TAIL: w_raddr = w_prev_tail;
            RD_HEAD:      w_raddr = r_head;
            default:      w_raddr = r_head;
        endcase
    end

    always_comb begin
        if (i_cmd.wr_shift) begin
            w_wr_entry = w_rd_entry;
        end else begin
            w_wr_entry.tag   = r_req.tag;
            w_wr_entry.value = r_req.value[VALUE_BITS-1:0];
        end
    end

    torbq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_shift | i_cmd.wr_new),
        .i_waddr(r_idx),
        .i_wdata(w_wr_entry),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.idx_init) begin
            r_idx <= r_tail;
        end else if (i_cmd.wr_shift) begin
            r_idx <= w_prev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_status    <= 1'b0;
            r_bus_holds <= 1'b0;
            r_bus_tag   <= '0;
            r_bus_value <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_status <= 1'b0;
            end else if (i_cmd.set_full) begin
                r_status <= 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_tail <= slot_next(r_tail);
            end else if (i_cmd.tail_back) begin
                r_tail <= w_prev_tail;
            end
            if (i_cmd.bus_load) begin
                r_head      <= slot_next(r_head);
                r_bus_holds <= 1'b1;
                r_bus_tag   <= w_rd_entry.tag;
                r_bus_value <= w_rd_entry.value;
            end else if (i_cmd.bus_squash && r_bus_holds &&
                         is_younger(r_req.tag, r_bus_tag, r_req.rob_front, r_req.rob_rear)) begin
                r_bus_holds <= 1'b0;
            end
        end
    end

    assign o_stat.req_type          = r_req.req_type;
    assign o_stat.full              = (slot_next(r_tail) == r_head);
    assign o_stat.empty             = (r_head == r_tail);
    assign o_stat.idx_at_head       = (r_idx == r_head);
    assign o_stat.prev_tail_at_head = (w_prev_tail == r_head);
    assign o_stat.shift_ok          = (w_rd_entry.tag >= r_req.tag);
    assign o_stat.younger_rd        = is_younger(r_req.tag, w_rd_entry.tag,
                                                 r_req.rob_front, r_req.rob_rear);

    assign w_occ = (r_tail >= r_head) ? (PTR_W + 1)'(r_tail) - (PTR_W + 1)'(r_head)
                                      : (PTR_W + 1)'(r_tail) + SLOT_SIZE - (PTR_W + 1)'(r_head);

    assign o_result.status    = r_status;
    assign o_result.bus_valid = r_bus_holds;
    assign o_result.bus_tag   = r_bus_holds ? r_bus_tag : '0;
    assign o_result.bus_value = r_bus_holds ? WORD_W'(r_bus_value) : '0;
    assign o_result.occupancy = w_occ[OCC_W-1:0];

endmodule

/* rtl/core/torbq_ctrl.sv */
// Controller of the result bus queue: sequences enqueue shifts, squash walks and ticks.
// Depends on torbq_pkg and the assertion macros header.
`include "tag_ordered_result_bus_queue_defines.svh"

module torbq_ctrl import torbq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENQ_CHK,
        S_ENQ_CMP,
        S_SQ_CHK,
        S_SQ_CMP,
        S_TICK_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_HEAD;
        case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    o_cmd.latch = 1'b1;
                    n_busy  = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req_type)
                    REQ_ENQUEUE: begin
                        if (i_stat.full) begin
                            o_cmd.set_full = 1'b1;
                            n_state = S_IDLE;
                            n_busy  = 1'b0;
                            n_done  = 1'b1;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                            n_state = S_ENQ_CHK;
                        end
                    end
                    REQ_SQUASH: begin
                        if (i_stat.empty) begin
                            n_state = S_IDLE;
                            n_busy  = 1'b0;
                            n_done  = 1'b1;
                        end else begin
                            n_state = S_SQ_CHK;
                        end
                    end
                    REQ_TICK: begin
                        if (i_stat.empty) begin
                            n_state = S_IDLE;
                            n_busy  = 1'b0;
                            n_done  = 1'b1;
                        end else begin
                            o_cmd.rd_sel = RD_HEAD;
                            n_state = S_TICK_WR;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                        n_busy  = 1'b0;
                        n_done  = 1'b1;
                    end
                endcase
            end
            S_ENQ_CHK: begin
                if (i_stat.idx_at_head) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end else begin
                    o_cmd.rd_sel = RD_PREV_IDX;
                    n_state = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP: begin
                if (i_stat.shift_ok) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state = S_ENQ_CHK;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end
            end
            S_SQ_CHK: begin
                if (i_stat.prev_tail_at_head) begin
                    o_cmd.bus_squash = 1'b1;
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end else begin
                    o_cmd.rd_sel = RD_PREV_TAIL;
                    n_state = S_SQ_CMP;
                end
            end
            S_SQ_CMP: begin
                if (i_stat.younger_rd) begin
                    o_cmd.tail_back = 1'b1;
                    n_state = S_SQ_CHK;
                end else begin
                    o_cmd.bus_squash = 1'b1;
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end
            end
            S_TICK_WR: begin
                o_cmd.bus_load = 1'b1;
                n_state = S_IDLE;
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    `TORBQ_ASSERT_SAME(a_done_not_busy, r_done, !r_busy, "Result strobe while still busy.")
    `TORBQ_ASSERT_NEXT(a_accept_sets_busy, i_start && !r_busy, r_busy, "Accepted item did not set busy.")
    `TORBQ_ASSERT_NEXT(a_done_single, r_done, !r_done, "Result strobe lasted more than one cycle.")
    `TORBQ_ASSERT_SAME(a_busy_matches_state, r_busy, r_state != S_IDLE, "Busy outside a working state.")
    `TORBQ_ASSERT_SAME(a_cmp_after_chk, r_state == S_ENQ_CMP, $past(r_state) == S_ENQ_CHK, "Compare without read.")

endmodule

/* rtl/core/tag_ordered_result_bus_queue.sv */
// Tag-ordered result bus queue: a request is accepted when i_start is high and o_busy low.
// A refused (full-queue), unused or empty-queue request ends at dispatch; a tick loads the head
// entry onto the bus; an enqueue or squash walks the queue one entry at a time until a compare or
// the head ends the walk. Only one request is in flight at a time; the next may be accepted in the
// strobe cycle. The slot memory has one read port, so each shift or squash step takes a read
// and a compare. Reset (synchronous, active low) empties the queue and the bus; o_done is not stallable.
module tag_ordered_result_bus_queue import torbq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_req    i_req,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;

    torbq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_busy (o_busy),
        .o_done (o_done)
    );

    torbq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_result(o_result)
    );

endmodule
